/* src/ngga_pkg.sv */
// Shared types, character codes and number helpers for the GGA sentence parser.
package ngga_pkg;

    localparam int MINUTE_FRACTION_DIGITS_DEF = 5;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_UN    = 8'h4E;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_US    = 8'h53;
    localparam logic [7:0] CH_UW    = 8'h57;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    localparam logic [1:0] NUM_INT  = 2'd0;
    localparam logic [1:0] NUM_FRAC = 2'd1;
    localparam logic [1:0] NUM_STOP = 2'd2;

    localparam logic [33:0] RECIP60   = 34'((64'd1 << 38) / 60);
    localparam logic [23:0] DEG_SCALE = 24'd10_000_000;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FMT   = 2'd1,
        ST_NOFIX = 2'd2,
        ST_NOPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_BODY    = 3'b010,
        PH_DISCARD = 3'b100
    } t_phase;

    typedef struct packed {
        logic [31:0] val;
        logic [1:0]  ph;
        logic [2:0]  frac;
    } t_num;

    typedef struct packed {
        logic [9:0]  deg;
        logic [31:0] mins;
        logic        neg;
    } t_coord_in;

    typedef struct packed {
        t_status            status;
        logic [3:0]         quality;
        logic signed [27:0] alt;
        t_coord_in          lat;
        t_coord_in          lon;
    } t_snap;

    typedef struct packed {
        t_status            status;
        logic [3:0]         quality;
        logic signed [27:0] alt;
    } t_side;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] r;
        case (n)
            3'd0: r = 20'd1;
            3'd1: r = 20'd10;
            3'd2: r = 20'd100;
            3'd3: r = 20'd1000;
            3'd4: r = 20'd10000;
            3'd5: r = 20'd100000;
            3'd6: r = 20'd1000000;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

    // Feeds one character into a decimal accumulator kept as value * 10^fd.
    function automatic t_num num_feed(input t_num n, input logic [7:0] c,
                                      input logic [2:0] fd, input logic [31:0] cap);
        t_num        r;
        logic [63:0] v;
        logic [3:0]  d;
        logic        upd;
        r   = n;
        v   = '0;
        d   = c[3:0];
        upd = 1'b0;
        if (n.ph != NUM_STOP) begin
            if (c inside {[CH_0:CH_9]}) begin
                if (n.ph == NUM_INT) begin
                    v   = 64'(n.val) * 64'd10 + 64'(d) * 64'(pow10(fd));
                    upd = 1'b1;
                end else if (n.frac < fd) begin
                    r.frac = n.frac + 3'd1;
                    v      = 64'(n.val) + 64'(d) * 64'(pow10(fd - r.frac));
                    upd    = 1'b1;
                end
            end else if (c == CH_DOT && n.ph == NUM_INT) begin
                r.ph = NUM_FRAC;
            end else begin
                r.ph = NUM_STOP;
            end
        end
        if (upd) begin
            r.val = (v > 64'(cap)) ? cap : v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/ngga_parse.sv */
// Byte-level sentence state: header match, checksum, field index and accumulators.
module ngga_parse import ngga_pkg::*; #(
    parameter int MINUTE_FRACTION_DIGITS = MINUTE_FRACTION_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    output logic        o_line_end,
    output t_snap       o_snap
);

    localparam logic [2:0] MFD = 3'(MINUTE_FRACTION_DIGITS);
    localparam logic [4:0] FLD_LAT  = 5'd2;
    localparam logic [4:0] FLD_NS   = 5'd3;
    localparam logic [4:0] FLD_LON  = 5'd4;
    localparam logic [4:0] FLD_EW   = 5'd5;
    localparam logic [4:0] FLD_QUAL = 5'd6;
    localparam logic [4:0] FLD_ALT  = 5'd9;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_hdr, n_hdr;
    logic [3:0]         r_len, n_len;
    logic [7:0]         r_rxor, n_rxor;
    logic [7:0]         r_xstar, n_xstar;
    logic               r_star, n_star;
    logic [7:0]         r_ckd, n_ckd;
    logic [1:0]         r_ckc, n_ckc;
    logic [4:0]         r_fidx, n_fidx;
    logic [3:0]         r_fcc, n_fcc;
    logic [9:0]         r_lat_deg [2], n_lat_deg [2], cl_lat_deg [2];
    logic [31:0]        r_lat_min [2], n_lat_min [2], cl_lat_min [2];
    logic [9:0]         r_lon_deg [2], n_lon_deg [2], cl_lon_deg [2];
    logic [31:0]        r_lon_min [2], n_lon_min [2], cl_lon_min [2];
    logic [15:0]        r_hemi, n_hemi;
    logic signed [27:0] r_alt, n_alt, cl_alt;
    logic [3:0]         r_qual, n_qual, cl_qual;
    logic [5:0]         r_flags, n_flags, cl_flags;
    t_num               r_cdeg [2], n_cdeg [2];
    t_num               r_cmin [2], n_cmin [2];
    t_num               r_cnum, n_cnum;
    logic               r_cneg, n_cneg;

    logic       is_blank;
    logic       hdr_ok;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       sum_ok;
    logic       clr;
    t_status    status;
    logic       lat_s, lon_s;
    logic [7:0] lat_dir, lon_dir;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = CH_DOLLAR;
            3'd1:    r = CH_UG;
            3'd2:    r = CH_UP;
            3'd3:    r = CH_UG;
            3'd4:    r = CH_UG;
            3'd5:    r = CH_UA;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    assign is_blank   = i_byte inside {CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE};
    assign o_line_end = (i_byte == CH_LF) && (r_phase == PH_BODY);
    assign clr        = i_valid && (i_byte == CH_LF);

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = i_byte[3:0];
        if (i_byte inside {[CH_0:CH_9]}) begin
            hex_val = i_byte[3:0];
        end else if (i_byte inside {[CH_UA:CH_UF], [CH_LA:CH_LF_HEX]}) begin
            hex_val = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Values the field registers take when the current field closes.
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            cl_lat_deg[s] = r_lat_deg[s];
            cl_lat_min[s] = r_lat_min[s];
            cl_lon_deg[s] = r_lon_deg[s];
            cl_lon_min[s] = r_lon_min[s];
        end
        cl_flags = r_flags;
        cl_qual  = r_qual;
        cl_alt   = r_alt;
        case (r_fidx)
            FLD_LAT: begin
                for (int s = 0; s < 2; s++) begin
                    cl_lat_deg[s] = r_cdeg[s].val[9:0];
                    cl_lat_min[s] = r_cmin[s].val;
                end
                if (r_fcc != 4'd0) cl_flags[0] = 1'b1;
                if (r_fcc >= 4'd4) cl_flags[4] = 1'b1;
            end
            FLD_LON: begin
                for (int s = 0; s < 2; s++) begin
                    cl_lon_deg[s] = r_cdeg[s].val[9:0];
                    cl_lon_min[s] = r_cmin[s].val;
                end
                if (r_fcc != 4'd0) cl_flags[2] = 1'b1;
                if (r_fcc >= 4'd4) cl_flags[5] = 1'b1;
            end
            FLD_NS: begin
                if (r_fcc != 4'd0) cl_flags[1] = 1'b1;
            end
            FLD_EW: begin
                if (r_fcc != 4'd0) cl_flags[3] = 1'b1;
            end
            FLD_QUAL: begin
                cl_qual = r_cnum.val[3:0];
            end
            FLD_ALT: begin
                cl_alt = r_cneg ? -28'(r_cnum.val[26:0]) : 28'(r_cnum.val[26:0]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_rxor  = r_rxor;
        n_xstar = r_xstar;
        n_star  = r_star;
        n_ckd   = r_ckd;
        n_ckc   = r_ckc;
        n_fidx  = r_fidx;
        n_fcc   = r_fcc;
        for (int s = 0; s < 2; s++) begin
            n_lat_deg[s] = r_lat_deg[s];
            n_lat_min[s] = r_lat_min[s];
            n_lon_deg[s] = r_lon_deg[s];
            n_lon_min[s] = r_lon_min[s];
            n_cdeg[s]    = r_cdeg[s];
            n_cmin[s]    = r_cmin[s];
        end
        n_hemi  = r_hemi;
        n_alt   = r_alt;
        n_qual  = r_qual;
        n_flags = r_flags;
        n_cnum  = r_cnum;
        n_cneg  = r_cneg;
        hdr_ok  = (r_hdr < 3'd6) &&
                  (i_byte == hdr_char(r_hdr) || (r_hdr == 3'd2 && i_byte == CH_UN));
        if (i_valid && !clr && !is_blank && r_phase != PH_DISCARD) begin
            if (r_len != 4'd15) n_len = r_len + 4'd1;
            if (r_phase == PH_HEADER) begin
                if (!hdr_ok) begin
                    n_phase = PH_DISCARD;
                end else begin
                    if (r_hdr != 3'd0) n_rxor = r_rxor ^ i_byte;
                    n_hdr = r_hdr + 3'd1;
                    if (r_hdr == 3'd5) begin
                        n_phase = PH_BODY;
                        n_fcc   = 4'd6;
                    end
                end
            end else begin
                if (i_byte == CH_STAR) begin
                    n_xstar = r_rxor;
                    n_star  = 1'b1;
                    n_ckd   = 8'd0;
                    n_ckc   = 2'd0;
                end else if (r_star) begin
                    if (!hex_ok || r_ckc >= 2'd2) begin
                        n_ckc = 2'd3;
                    end else begin
                        n_ckd = {r_ckd[3:0], hex_val};
                        n_ckc = r_ckc + 2'd1;
                    end
                end
                n_rxor = r_rxor ^ i_byte;
                if (i_byte == CH_COMMA) begin
                    for (int s = 0; s < 2; s++) begin
                        n_lat_deg[s] = cl_lat_deg[s];
                        n_lat_min[s] = cl_lat_min[s];
                        n_lon_deg[s] = cl_lon_deg[s];
                        n_lon_min[s] = cl_lon_min[s];
                        n_cdeg[s]    = '0;
                        n_cmin[s]    = '0;
                    end
                    n_flags = cl_flags;
                    n_qual  = cl_qual;
                    n_alt   = cl_alt;
                    n_cnum  = '0;
                    n_cneg  = 1'b0;
                    if (r_fidx != 5'd31) n_fidx = r_fidx + 5'd1;
                    n_fcc = 4'd0;
                end else begin
                    if (r_fidx == FLD_LAT || r_fidx == FLD_LON) begin
                        for (int s = 0; s < 2; s++) begin
                            if (r_fcc < 4'(s + 2)) begin
                                n_cdeg[s] = num_feed(r_cdeg[s], i_byte, 3'd0, 32'd999);
                            end else begin
                                n_cmin[s] = num_feed(r_cmin[s], i_byte, MFD, 32'hFFFF_FFFF);
                            end
                        end
                    end else if (r_fidx == FLD_NS && r_fcc == 4'd0) begin
                        n_hemi[7:0] = i_byte;
                    end else if (r_fidx == FLD_EW && r_fcc == 4'd0) begin
                        n_hemi[15:8] = i_byte;
                    end else if (r_fidx == FLD_QUAL) begin
                        n_cnum = num_feed(r_cnum, i_byte, 3'd0, 32'd15);
                    end else if (r_fidx == FLD_ALT) begin
                        if (r_fcc == 4'd0 && (i_byte == CH_MINUS || i_byte == CH_PLUS)) begin
                            n_cneg = (i_byte == CH_MINUS);
                        end else begin
                            n_cnum = num_feed(r_cnum, i_byte, 3'd2, 32'd100_000_000);
                        end
                    end
                    if (r_fcc != 4'd15) n_fcc = r_fcc + 4'd1;
                end
            end
        end
    end

    always_comb begin
        sum_ok = !r_star || (r_ckc == 2'd2 && r_ckd == r_xstar);
        if (r_len < 4'd10 || !sum_ok) begin
            status = ST_FMT;
        end else if (r_fidx < 5'd9 || cl_qual == 4'd0) begin
            status = ST_NOFIX;
        end else if (cl_flags[3:0] != 4'hF) begin
            status = ST_NOPOS;
        end else begin
            status = ST_OK;
        end
        lat_dir = r_hemi[7:0];
        lon_dir = r_hemi[15:8];
        lat_s   = !(lat_dir == CH_UN || lat_dir == CH_US);
        lon_s   = !(lon_dir == CH_UN || lon_dir == CH_US);
        o_snap.status  = status;
        o_snap.quality = cl_qual;
        o_snap.alt     = (status == ST_OK) ? cl_alt : 28'sd0;
        o_snap.lat.neg = (lat_dir == CH_US || lat_dir == CH_UW);
        o_snap.lon.neg = (lon_dir == CH_US || lon_dir == CH_UW);
        if (status == ST_OK && cl_flags[4]) begin
            o_snap.lat.deg  = cl_lat_deg[lat_s];
            o_snap.lat.mins = cl_lat_min[lat_s];
        end else begin
            o_snap.lat.deg  = 10'd0;
            o_snap.lat.mins = 32'd0;
        end
        if (status == ST_OK && cl_flags[5]) begin
            o_snap.lon.deg  = cl_lon_deg[lon_s];
            o_snap.lon.mins = cl_lon_min[lon_s];
        end else begin
            o_snap.lon.deg  = 10'd0;
            o_snap.lon.mins = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_phase <= PH_HEADER;
            r_hdr   <= '0;
            r_len   <= '0;
            r_rxor  <= '0;
            r_xstar <= '0;
            r_star  <= 1'b0;
            r_ckd   <= '0;
            r_ckc   <= '0;
            r_fidx  <= '0;
            r_fcc   <= '0;
            for (int s = 0; s < 2; s++) begin
                r_lat_deg[s] <= '0;
                r_lat_min[s] <= '0;
                r_lon_deg[s] <= '0;
                r_lon_min[s] <= '0;
                r_cdeg[s]    <= '0;
                r_cmin[s]    <= '0;
            end
            r_hemi  <= '0;
            r_alt   <= '0;
            r_qual  <= '0;
            r_flags <= '0;
            r_cnum  <= '0;
            r_cneg  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_len   <= n_len;
            r_rxor  <= n_rxor;
            r_xstar <= n_xstar;
            r_star  <= n_star;
            r_ckd   <= n_ckd;
            r_ckc   <= n_ckc;
            r_fidx  <= n_fidx;
            r_fcc   <= n_fcc;
            for (int s = 0; s < 2; s++) begin
                r_lat_deg[s] <= n_lat_deg[s];
                r_lat_min[s] <= n_lat_min[s];
                r_lon_deg[s] <= n_lon_deg[s];
                r_lon_min[s] <= n_lon_min[s];
                r_cdeg[s]    <= n_cdeg[s];
                r_cmin[s]    <= n_cmin[s];
            end
            r_hemi  <= n_hemi;
            r_alt   <= n_alt;
            r_qual  <= n_qual;
            r_flags <= n_flags;
            r_cnum  <= n_cnum;
            r_cneg  <= n_cneg;
        end
    end

    a_body_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> r_hdr == 3'd6)
        else $error("body phase without a complete header");

    a_no_digits_before_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_star |-> (r_ckc == 2'd0 && r_ckd == 8'd0))
        else $error("checksum digits collected before a star");

    a_ck_overrun_needs_star: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ckc == 2'd3 |-> r_star)
        else $error("checksum overrun without a star");

endmodule

/* src/ngga_coord.sv */
// Coordinate arithmetic: degrees and scaled minutes to signed 1e-7 degrees.
module ngga_coord import ngga_pkg::*; #(
    parameter int MINUTE_FRACTION_DIGITS = MINUTE_FRACTION_DIGITS_DEF
) (
    input  logic        i_clk,
    input  t_stage_en   i_en,
    input  t_coord_in   i_coord,
    output logic [31:0] o_value
);

    localparam int POW_SH = 10 ** (7 - MINUTE_FRACTION_DIGITS);

    logic [19:0] frac_tbl [64];

    for (genvar gi = 0; gi < 64; gi++) begin : g_tbl
        if (gi < 60) begin : g_used
            assign frac_tbl[gi] = 20'((gi * POW_SH) / 60);
        end else begin : g_unused
            assign frac_tbl[gi] = 20'd0;
        end
    end

    logic [26:0] r_a2;
    logic [33:0] r_degp2, r_degp3, r_degp4;
    logic [31:0] r_min2;
    logic        r_neg2, r_neg3, r_neg4;
    logic [26:0] r_a3;
    logic [5:0]  r_b3;
    logic [46:0] r_ap4;
    logic [19:0] r_t4;

    logic [66:0] prod;
    logic [31:0] b_wide;
    logic [6:0]  b_raw;
    logic [26:0] a_fix;
    logic [5:0]  b_fix;
    logic [47:0] mag_sum;
    logic [47:0] lim;
    logic [31:0] mag;

    assign prod = 67'(i_coord.mins) * 67'(RECIP60);

    always_comb begin
        b_wide = r_min2 - 32'(r_a2 * 27'd60);
        b_raw  = b_wide[6:0];
        if (b_raw >= 7'd60) begin
            a_fix = r_a2 + 27'd1;
            b_fix = 6'(b_raw - 7'd60);
        end else begin
            a_fix = r_a2;
            b_fix = b_raw[5:0];
        end
        mag_sum = 48'(r_degp4) + 48'(r_ap4) + 48'(r_t4);
        lim     = r_neg4 ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
        mag     = (mag_sum > lim) ? lim[31:0] : mag_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_a2    <= prod[64:38];
            r_degp2 <= 34'(i_coord.deg) * 34'(DEG_SCALE);
            r_min2  <= i_coord.mins;
            r_neg2  <= i_coord.neg;
        end
        if (i_en.s3) begin
            r_a3    <= a_fix;
            r_b3    <= b_fix;
            r_degp3 <= r_degp2;
            r_neg3  <= r_neg2;
        end
        if (i_en.s4) begin
            r_ap4   <= 47'(r_a3) * 47'(POW_SH);
            r_t4    <= frac_tbl[r_b3];
            r_degp4 <= r_degp3;
            r_neg4  <= r_neg3;
        end
        if (i_en.s5) begin
            o_value <= r_neg4 ? (32'd0 - mag) : mag;
        end
    end

endmodule

/* src/nmea_gga_position_parser.sv */
// Top level of the NMEA GGA position parser with its result pipeline.
//
//  Channel  | Direction | Beat content
//  s_axis   | in        | tdata[7:0] one received character
//  m_axis   | out       | tdata: status, fix_quality, latitude, longitude, altitude
//
// One character is taken per cycle unless a line feed waits on a full pipeline.
// Each result passes an input register, the parser, then four arithmetic stages
// for the coordinate conversion (reciprocal multiply by 1/60, correction,
// scaling, saturating sum). Synchronous active-low reset clears the parser and
// all valid flags. A stall on the output only backs up the stages that are full.
module nmea_gga_position_parser import ngga_pkg::*; #(
    parameter int MINUTE_FRACTION_DIGITS = MINUTE_FRACTION_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // status, fix_quality, latitude, longitude,
                                         // altitude, zero padding
);

    logic       r_in_v;
    logic [7:0] r_in_byte;
    logic       r_v1, r_v2, r_v3, r_v4, r_v5;
    t_snap      r_snap;
    t_side      r_side2, r_side3, r_side4, r_side5;

    logic      free_in, free1, free2, free3, free4, free5;
    logic      line_end;
    logic      parse_go;
    t_snap     snap;
    t_stage_en en;
    logic [31:0] lat_val, lon_val;

    assign free5    = !r_v5 || m_axis_tready;
    assign free4    = !r_v4 || free5;
    assign free3    = !r_v3 || free4;
    assign free2    = !r_v2 || free3;
    assign free1    = !r_v1 || free2;
    assign parse_go = !line_end || free1;
    assign free_in  = !r_in_v || parse_go;

    assign s_axis_tready = free_in;
    assign en = '{s2: free2, s3: free3, s4: free4, s5: free5};

    ngga_parse #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_v && parse_go),
        .i_byte     (r_in_byte),
        .o_line_end (line_end),
        .o_snap     (snap)
    );

    ngga_coord #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
    ) u_lat (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (r_snap.lat),
        .o_value (lat_val)
    );

    ngga_coord #(
        .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)
    ) u_lon (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_coord (r_snap.lon),
        .o_value (lon_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
        end else begin
            if (free_in) r_in_v <= s_axis_tvalid;
            if (free1)   r_v1   <= r_in_v && line_end;
            if (free2)   r_v2   <= r_v1;
            if (free3)   r_v3   <= r_v2;
            if (free4)   r_v4   <= r_v3;
            if (free5)   r_v5   <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_in) r_in_byte <= s_axis_tdata;
        if (free1)   r_snap    <= snap;
        if (free2)   r_side2   <= '{status: r_snap.status, quality: r_snap.quality,
                                    alt: r_snap.alt};
        if (free3)   r_side3   <= r_side2;
        if (free4)   r_side4   <= r_side3;
        if (free5)   r_side5   <= r_side4;
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {6'd0, r_side5.alt, lon_val, lat_val, r_side5.quality,
                            r_side5.status};

    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && r_side5.status != ST_OK) |->
            (lat_val == 32'd0 && lon_val == 32'd0 && r_side5.alt == 28'sd0))
        else $error("position given with a failing status");

endmodule

/* verif/nmea_gga_position_parser_test.sv */
// Self-checking testbench for the GGA sentence parser: directed and random sentences.
module nmea_gga_position_parser_test;
    import ngga_pkg::*;

    localparam int FRAC_DIGITS = MINUTE_FRACTION_DIGITS_DEF;

    typedef struct {
        t_status     status;
        logic [3:0]  quality;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [27:0] alt;
    } t_fix;

    class gga_fix_scoreboard;
        t_fix        fix_q[$];
        int          errors;
        t_phase      phase;
        int          hdr_pos;
        int          line_len;
        logic [7:0]  run_xor;
        logic [7:0]  xor_star;
        bit          star;
        logic [7:0]  sum_digits;
        int          sum_count;
        int          fld;
        int          fld_chars;
        int unsigned lat_deg[2];
        int unsigned lat_min[2];
        int unsigned lon_deg[2];
        int unsigned lon_min[2];
        logic [7:0]  hemi_lat;
        logic [7:0]  hemi_lon;
        int          alt_acc;
        int unsigned qual_acc;
        logic [5:0]  present;
        t_num        acc_deg[2];
        t_num        acc_min[2];
        t_num        acc_num;
        bit          acc_neg;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase = PH_HEADER;
            hdr_pos = 0;
            line_len = 0;
            run_xor = 0;
            xor_star = 0;
            star = 0;
            sum_digits = 0;
            sum_count = 0;
            fld = 0;
            fld_chars = 0;
            for (int s = 0; s < 2; s++) begin
                lat_deg[s] = 0;
                lat_min[s] = 0;
                lon_deg[s] = 0;
                lon_min[s] = 0;
                acc_deg[s] = '0;
                acc_min[s] = '0;
            end
            hemi_lat = 0;
            hemi_lon = 0;
            alt_acc = 0;
            qual_acc = 0;
            present = 0;
            acc_num = '0;
            acc_neg = 0;
        endfunction

        function longint unsigned ten_pow(int n);
            longint unsigned r;
            r = 1;
            for (int i = 0; i < n; i++) r *= 10;
            return r;
        endfunction

        function t_num add_char(t_num n, logic [7:0] c, int fd, longint unsigned cap);
            t_num            r;
            longint unsigned v;
            r = n;
            if (n.ph == NUM_STOP) return r;
            if (c >= CH_0 && c <= CH_9) begin
                if (n.ph == NUM_INT) begin
                    v = longint'(n.val) * 10 + longint'(c - CH_0) * ten_pow(fd);
                end else if (n.frac < fd) begin
                    r.frac = n.frac + 1;
                    v = longint'(n.val) + longint'(c - CH_0) * ten_pow(fd - r.frac);
                end else begin
                    return r;
                end
                r.val = (v > cap) ? cap[31:0] : v[31:0];
            end else if (c == CH_DOT && n.ph == NUM_INT) begin
                r.ph = NUM_FRAC;
            end else begin
                r.ph = NUM_STOP;
            end
            return r;
        endfunction

        function void close_field();
            for (int s = 0; s < 2; s++) begin
                if (fld == 2) begin
                    lat_deg[s] = acc_deg[s].val;
                    lat_min[s] = acc_min[s].val;
                end else if (fld == 4) begin
                    lon_deg[s] = acc_deg[s].val;
                    lon_min[s] = acc_min[s].val;
                end
            end
            if (fld == 2 && fld_chars > 0) present[0] = 1;
            if (fld == 2 && fld_chars >= 4) present[4] = 1;
            if (fld == 4 && fld_chars > 0) present[2] = 1;
            if (fld == 4 && fld_chars >= 4) present[5] = 1;
            if (fld == 3 && fld_chars > 0) present[1] = 1;
            if (fld == 5 && fld_chars > 0) present[3] = 1;
            if (fld == 6) qual_acc = acc_num.val;
            if (fld == 9) alt_acc = acc_neg ? -int'(acc_num.val) : int'(acc_num.val);
            for (int s = 0; s < 2; s++) begin
                acc_deg[s] = '0;
                acc_min[s] = '0;
            end
            acc_num = '0;
            acc_neg = 0;
        endfunction

        function void field_char(logic [7:0] c);
            if (fld == 2 || fld == 4) begin
                for (int s = 0; s < 2; s++) begin
                    if (fld_chars < 2 + s) acc_deg[s] = add_char(acc_deg[s], c, 0, 999);
                    else acc_min[s] = add_char(acc_min[s], c, FRAC_DIGITS, 64'hFFFF_FFFF);
                end
            end else if (fld == 3 && fld_chars == 0) begin
                hemi_lat = c;
            end else if (fld == 5 && fld_chars == 0) begin
                hemi_lon = c;
            end else if (fld == 6) begin
                acc_num = add_char(acc_num, c, 0, 15);
            end else if (fld == 9) begin
                if (fld_chars == 0 && (c == CH_MINUS || c == CH_PLUS)) acc_neg = (c == CH_MINUS);
                else acc_num = add_char(acc_num, c, 2, 100000000);
            end
            if (fld_chars < 15) fld_chars++;
        endfunction

        function logic [31:0] coord(logic [7:0] dir, int unsigned deg[2],
                                    int unsigned mins[2], bit long_enough);
            int              s;
            bit              neg;
            longint unsigned mag;
            longint unsigned lim;
            s = (dir == CH_UN || dir == CH_US) ? 0 : 1;
            neg = (dir == CH_US || dir == CH_UW);
            lim = neg ? 64'd2147483648 : 64'd2147483647;
            if (!long_enough) return 0;
            mag = longint'(deg[s]) * 10000000 + (longint'(mins[s]) * ten_pow(7 - FRAC_DIGITS)) / 60;
            if (mag > lim) mag = lim;
            return neg ? -mag[31:0] : mag[31:0];
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= CH_0 && c <= CH_9) return c - CH_0;
            if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
            if (c >= CH_LA && c <= CH_LF_HEX) return c - CH_LA + 10;
            return -1;
        endfunction

        function void note_rx_byte(logic [7:0] c);
            logic [7:0] hdr[6];
            t_fix       f;
            bit         sum_ok;
            int         h;
            hdr = '{CH_DOLLAR, CH_UG, CH_UP, CH_UG, CH_UG, CH_UA};
            if (c == CH_LF) begin
                if (phase == PH_BODY) begin
                    close_field();
                    sum_ok = !star || (sum_count == 2 && sum_digits == xor_star);
                    if (line_len < 10 || !sum_ok) f.status = ST_FMT;
                    else if (fld < 9 || qual_acc == 0) f.status = ST_NOFIX;
                    else if (present[3:0] != 4'hF) f.status = ST_NOPOS;
                    else f.status = ST_OK;
                    f.quality = qual_acc[3:0];
                    f.lat = 0;
                    f.lon = 0;
                    f.alt = 0;
                    if (f.status == ST_OK) begin
                        f.lat = coord(hemi_lat, lat_deg, lat_min, present[4]);
                        f.lon = coord(hemi_lon, lon_deg, lon_min, present[5]);
                        f.alt = alt_acc[27:0];
                    end
                    fix_q.push_back(f);
                end
                clear_line();
                return;
            end
            if (c inside {CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE}) return;
            if (phase == PH_DISCARD) return;
            if (line_len < 15) line_len++;
            if (phase == PH_HEADER) begin
                if (!(hdr_pos < 6 && (c == hdr[hdr_pos] || (hdr_pos == 2 && c == CH_UN)))) begin
                    phase = PH_DISCARD;
                    return;
                end
                if (hdr_pos > 0) run_xor ^= c;
                hdr_pos++;
                if (hdr_pos == 6) begin
                    phase = PH_BODY;
                    fld_chars = 6;
                end
                return;
            end
            if (c == CH_STAR) begin
                xor_star = run_xor;
                star = 1;
                sum_digits = 0;
                sum_count = 0;
            end else if (star) begin
                h = hex_digit(c);
                if (h < 0 || sum_count >= 2) begin
                    sum_count = 3;
                end else begin
                    sum_digits = {sum_digits[3:0], h[3:0]};
                    sum_count++;
                end
            end
            run_xor ^= c;
            if (c == CH_COMMA) begin
                close_field();
                if (fld < 31) fld++;
                fld_chars = 0;
            end else begin
                field_char(c);
            end
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void check_fix(logic [103:0] d);
            t_fix f;
            if (fix_q.size() == 0) begin
                report($sformatf("unexpected result beat %h", d));
                return;
            end
            f = fix_q.pop_front();
            if (d[1:0] != f.status)
                report($sformatf("status %0d, predicted %0d", d[1:0], f.status));
            if (d[5:2] != f.quality)
                report($sformatf("fix quality %0d, predicted %0d", d[5:2], f.quality));
            if (d[37:6] != f.lat)
                report($sformatf("latitude %0d, predicted %0d",
                                 $signed(d[37:6]), $signed(f.lat)));
            if (d[69:38] != f.lon)
                report($sformatf("longitude %0d, predicted %0d",
                                 $signed(d[69:38]), $signed(f.lon)));
            if (d[97:70] != f.alt)
                report($sformatf("altitude %0d, predicted %0d",
                                 $signed(d[97:70]), $signed(f.alt)));
            if (d[103:98] != 0)
                report($sformatf("padding bits %h", d[103:98]));
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [103:0] m_axis_tdata;

    gga_fix_scoreboard fix_board = new();
    int sender_idle = 13;
    int receiver_idle = 76;
    int bytes_sent = 0;

    nmea_gga_position_parser u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) fix_board.check_fix(m_axis_tdata);
    end

    task automatic push_byte(input logic [7:0] c);
        while ($urandom_range(99) < sender_idle) begin
            s_axis_tvalid <= 0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= c;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        fix_board.note_rx_byte(c);
        bytes_sent++;
    endtask

    task automatic send_line(input string s, input int blank_pct);
        logic [7:0] blanks[5];
        blanks = '{CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE};
        for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(99) < blank_pct) push_byte(blanks[$urandom_range(4)]);
            push_byte(s[i]);
        end
        push_byte(CH_LF);
    endtask

    function automatic string with_sum(string body, int kind);
        logic [7:0] x;
        x = 0;
        for (int i = 1; i < body.len(); i++) x ^= body[i];
        case (kind)
            0: return $sformatf("%s*%02X", body, x);
            1: return $sformatf("%s*%02x", body, x);
            2: return $sformatf("%s*%02X", body, x ^ 8'(1 << $urandom_range(7)));
            3: return body;
            4: return $sformatf("%s*%02X%c", body, x, 8'($urandom_range(33, 126)));
            5: return $sformatf("%s*%1X", body, x[3:0]);
            default: return $sformatf("%s*G%1X,*%02X", body, x[3:0], x ^ 8'h2A ^ 8'h2C);
        endcase
    endfunction

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
        return s;
    endfunction

    function automatic string coord_field(int deg_digits);
        case ($urandom_range(9))
            0: return "";
            1: return digits($urandom_range(1, 3));
            2: return digits($urandom_range(4, 14));
            3: return {digits(deg_digits + 1), ".", digits(2)};
            4: return {digits(deg_digits + 2), string'(8'($urandom_range(33, 126))), digits(3)};
            default: return {digits(deg_digits), digits(2), ".", digits($urandom_range(0, 8))};
        endcase
    endfunction

    function automatic string pick_of(string a, string b, string c, string d);
        case ($urandom_range(9))
            0: return c;
            1: return d;
            2, 3, 4, 5: return a;
            default: return b;
        endcase
    endfunction

    function automatic string random_gga();
        string f[15];
        string body;
        int    nf;
        f[0] = ($urandom_range(1)) ? "$GPGGA" : "$GNGGA";
        f[1] = {digits(6), ".", digits(2)};
        f[2] = coord_field(2);
        f[3] = pick_of("N", "S", "", string'(8'($urandom_range(65, 90))));
        f[4] = coord_field(3);
        f[5] = pick_of("E", "W", "", "N");
        f[6] = pick_of(digits(1), "1", "0", digits($urandom_range(2, 4)));
        f[7] = digits(2);
        f[8] = {digits(1), ".", digits(1)};
        f[9] = {pick_of("", "-", "+", ""), digits($urandom_range(0, 9)),
                pick_of(".", "", ".", "x"), digits($urandom_range(0, 4))};
        f[10] = "M";
        f[11] = {digits(2), ".", digits(1)};
        f[12] = "M";
        f[13] = "";
        f[14] = digits($urandom_range(0, 4));
        nf = ($urandom_range(9) == 0) ? $urandom_range(1, 14) : 15;
        body = f[0];
        for (int i = 1; i < nf; i++) body = {body, ",", f[i]};
        return with_sum(body, ($urandom_range(9) < 6) ? $urandom_range(1) : $urandom_range(2, 6));
    endfunction

    function automatic string noise_line();
        string s;
        int    n;
        n = $urandom_range(1, 30);
        s = "";
        case ($urandom_range(3))
            0: s = "$GPRMC,";
            1: s = "$GPGG";
            2: s = "$GNGGA";
            default: s = "";
        endcase
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(255)))};
        return s;
    endfunction

    task automatic set_idling();
        if (bytes_sent < 620) begin
            sender_idle = 13;
            receiver_idle = 76;
        end else if (bytes_sent < 1240) begin
            sender_idle = 76;
            receiver_idle = 13;
        end else begin
            sender_idle = 0;
            receiver_idle = 0;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_line(with_sum("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", 0), 0);
        send_line(with_sum("$GNGGA,0,9959.99999,S,99959.999999,W,15,0,0,-999999.999,M,,M,,", 1), 0);
        send_line(with_sum("$GPGGA,0,129999999999999,N,999999999999999,E,99,1,1,9999999.99,M,,,", 0), 0);
        send_line(with_sum("$GPGGA,0,0000.00000,N,00000.0000,E,1,1,1,+1000000.01,M", 0), 0);
        send_line(with_sum("$GPGGA,1,12,N,1,W,2,1,1,+100,M,,,,", 0), 0);
        send_line(with_sum("$GPGGA,1,4807.038,N,01131.000,E,0,08,0.9,545.4,M,,,,", 0), 0);
        send_line(with_sum("$GPGGA,1,4807.038,N,01131.000,E,1,08", 0), 0);
        send_line(with_sum("$GPGGA,1,4807.038,,01131.000,E,1,08,0.9,5,M,,,,", 0), 0);
        send_line("$GPGGA,", 0);
        send_line(with_sum("$GPGGA,1,4807.038,N,01131.000,E,1,08,0.9,5,M,,,,", 2), 0);
        send_line(with_sum("$GPGGA,1,4807.038,N,01131.000,E,1,08,0.9,5,M,,,,", 4), 0);
        send_line(with_sum("$GPGGA,1,4807.038,N,01131.000,E,1,08,0.9,5,M,,,,", 3), 0);
        send_line(with_sum("$GPGGA,1,4807.038,N,01131.000,E,1,08,0.9,5,M,,,,", 6), 0);
        send_line("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W", 0);
        send_line("$GPG", 0);
        send_line({" \t ", with_sum("$GNGGA,1,3000.5,S,12000.25,W,4,08,0.9,-12.345,M,,,,", 0)}, 20);
        send_line(noise_line(), 0);
        while (bytes_sent < 1850) begin
            set_idling();
            if ($urandom_range(99) < 75) send_line(random_gga(), 3);
            else send_line(noise_line(), 3);
        end
        s_axis_tvalid <= 0;
        while (fix_board.fix_q.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fix_board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(12 * 2_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
